/* sv/fpp_pkg.sv */
package fpp_pkg;

    // Default ring depth and fixed field widths.
    localparam int SLOTS_DEF  = 8;
    localparam int TIME_W     = 48;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 4;
    localparam int SLOT_W     = 3;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 64;
    localparam int RETRY_W    = 16;
    localparam int SKIP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LIMIT = 2'd1;
    localparam logic [RETRY_W-1:0]   RETRY_WAIT_RST = 16'd10;
    localparam logic [SKIP_W-1:0]    SKIP_LIMIT_RST = 8'd10;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_FILL         = 3'd0,
        REQ_TICK         = 3'd1,
        REQ_FLUSH_SYNC   = 3'd2,
        REQ_FLUSH_DECODE = 3'd3,
        REQ_EOS          = 3'd4
    } req_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FILLED       = 4'd0,
        ST_FILL_BLOCKED = 4'd1,
        ST_RING_FULL    = 4'd2,
        ST_EMPTY_WAIT   = 4'd3,
        ST_NOT_DUE      = 4'd4,
        ST_SHOWN        = 4'd5,
        ST_SKIPPED      = 4'd6,
        ST_EOF          = 4'd7,
        ST_FLUSHED      = 4'd8
    } status_t;

endpackage

/* sv/fpp_req_if.sv */
// Request channel: one transaction carries one request.
interface fpp_req_if import fpp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output req_type, output time_ms, input ready);
    modport sink   (input valid, input req_type, input time_ms, output ready);
endinterface

/* sv/fpp_res_if.sv */
// Result channel: one transaction carries the result of one request.
interface fpp_res_if import fpp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   wait_ms;
    logic [SLOT_W-1:0]   slot;
    logic                paused;
    logic                ready_res;
    logic [TIME_W-1:0]   head_time;
    logic                release_decoder;
    logic [CNT_W-1:0]    late_frames;
    logic [CNT_W-1:0]    skipped_frames;
    logic [TIME_W-1:0]   max_lateness;
    logic [SUM_W-1:0]    total_lateness;

    modport source (
        output valid, output status, output wait_ms, output slot, output paused,
        output ready_res, output head_time, output release_decoder,
        output late_frames, output skipped_frames, output max_lateness,
        output total_lateness, input ready
    );
    modport sink (
        input valid, input status, input wait_ms, input slot, input paused,
        input ready_res, input head_time, input release_decoder,
        input late_frames, input skipped_frames, input max_lateness,
        input total_lateness, output ready
    );
endinterface

/* sv/fpp_cfg_if.sv */
// Configuration write channel: one transaction writes one register.
interface fpp_cfg_if import fpp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/frame_presentation_pacer_top.sv */
// A request accepted into the input register is processed into the result register
// once that register is free or being emptied.
// Throughput: one request per cycle while results are taken; the slot time memory has
// two registered read ports that always track the play pointer and the slot after it.
// Reset: pointers, slot full flags, flags and statistics clear, pause sets, both
// configuration registers return to 10; slot times are undefined until written.
module frame_presentation_pacer_top import fpp_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    fpp_req_if.sink   req,
    fpp_res_if.source res,
    fpp_cfg_if.sink   cfg
);

    localparam int              PW       = $clog2(SLOTS);
    localparam logic [PW-1:0]   LAST     = PW'(SLOTS - 1);
    localparam logic [PW:0]     AHEAD    = (PW + 1)'(2 * SLOTS / 3);
    localparam logic [PW:0]     SLOTS_W  = (PW + 1)'(SLOTS);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers.
    logic [RETRY_W-1:0] retry_wait_reg;
    logic [SKIP_W-1:0]  skip_limit_reg;

    // Input register.
    logic              ireg_valid_reg;
    logic [REQ_W-1:0]  ireg_req_reg;
    logic [TIME_W-1:0] ireg_time_reg;

    // Pacer state.
    logic [SLOTS-1:0]  slot_full_reg, slot_full_next;
    logic [PW-1:0]     play_ptr_reg, play_ptr_next;
    logic [PW-1:0]     fill_ptr_reg, fill_ptr_next;
    logic              fill_blocked_reg, fill_blocked_next;
    logic              pause_flag_reg, pause_flag_next;
    logic              eof_latched_reg, eof_latched_next;
    logic              decoder_waiting_reg, decoder_waiting_next;
    logic [TIME_W-1:0] frame_period_reg, frame_period_next;
    logic [TIME_W-1:0] last_fill_reg, last_fill_next;
    logic [SKIP_W-1:0] consec_skips_reg, consec_skips_next;
    logic [CNT_W-1:0]  late_count_reg, late_count_next;
    logic [SUM_W-1:0]  late_sum_reg, late_sum_next;
    logic [TIME_W-1:0] late_peak_reg, late_peak_next;
    logic [CNT_W-1:0]  skip_count_reg, skip_count_next;

    // Slot time memory and its registered read ports.
    logic [TIME_W-1:0] display_times_mem [SLOTS];
    logic [TIME_W-1:0] head_time_reg;
    logic [TIME_W-1:0] next_time_reg;
    logic [PW-1:0]     rd_next_addr;
    logic              mem_we;

    // Result register.
    logic              res_valid_reg;
    status_t           status_reg, status_next;
    logic [TIME_W-1:0] wait_reg, wait_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              release_reg, release_next;

    logic              proc;
    logic [TIME_W-1:0] late;
    logic [SUM_W:0]    late_sum_wide;
    logic [PW-1:0]     play_inc;
    logic [PW:0]       ahead_sum;
    logic [PW-1:0]     ahead_idx;

    // A request is processed when the result register is free or being emptied.
    assign proc      = ireg_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !ireg_valid_reg || proc;
    assign cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_wait_reg <= RETRY_WAIT_RST;
            skip_limit_reg <= SKIP_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RETRY_WAIT: retry_wait_reg <= cfg.data[RETRY_W-1:0];
                CFG_SKIP_LIMIT: skip_limit_reg <= cfg.data[SKIP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ireg_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            ireg_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            ireg_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            ireg_req_reg  <= req.req_type;
            ireg_time_reg <= req.time_ms;
        end
    end

    // Shared arithmetic for a play tick.
    assign late          = ireg_time_reg - head_time_reg;
    assign late_sum_wide = {1'b0, late_sum_reg} + (SUM_W + 1)'(late);
    assign play_inc      = ptr_inc(play_ptr_reg);

    // Next state and result for the request in the input register.
    always_comb
    begin
        slot_full_next       = slot_full_reg;
        play_ptr_next        = play_ptr_reg;
        fill_ptr_next        = fill_ptr_reg;
        fill_blocked_next    = fill_blocked_reg;
        pause_flag_next      = pause_flag_reg;
        eof_latched_next     = eof_latched_reg;
        decoder_waiting_next = decoder_waiting_reg;
        frame_period_next    = frame_period_reg;
        last_fill_next       = last_fill_reg;
        consec_skips_next    = consec_skips_reg;
        late_count_next      = late_count_reg;
        late_sum_next        = late_sum_reg;
        late_peak_next       = late_peak_reg;
        skip_count_next      = skip_count_reg;
        status_next          = ST_FILL_BLOCKED;
        wait_next            = '0;
        slot_next            = '0;
        release_next         = 1'b0;
        mem_we               = 1'b0;

        if (proc)
        begin
            case (ireg_req_reg)
                REQ_FILL:
                begin
                    slot_next = SLOT_W'(fill_ptr_reg);
                    if (fill_blocked_reg)
                    begin
                        status_next = ST_FILL_BLOCKED;
                    end
                    else if (slot_full_reg[fill_ptr_reg])
                    begin
                        decoder_waiting_next = 1'b1;
                        status_next          = ST_RING_FULL;
                    end
                    else
                    begin
                        mem_we                        = 1'b1;
                        slot_full_next[fill_ptr_reg]  = 1'b1;
                        fill_ptr_next                 = ptr_inc(fill_ptr_reg);
                        if (frame_period_reg == '0)
                        begin
                            frame_period_next = ireg_time_reg - last_fill_reg;
                        end
                        last_fill_next = ireg_time_reg;
                        status_next    = ST_FILLED;
                    end
                end
                REQ_TICK:
                begin
                    slot_next = SLOT_W'(play_ptr_reg);
                    if (!slot_full_reg[play_ptr_reg])
                    begin
                        // Nothing to present: end of stream or try again later.
                        if (eof_latched_reg)
                        begin
                            status_next = ST_EOF;
                        end
                        else
                        begin
                            status_next = ST_EMPTY_WAIT;
                            wait_next   = TIME_W'(retry_wait_reg);
                        end
                    end
                    else if (head_time_reg > ireg_time_reg)
                    begin
                        status_next = ST_NOT_DUE;
                        wait_next   = head_time_reg - ireg_time_reg;
                    end
                    else
                    begin
                        // Lateness statistics.
                        if (late != '0)
                        begin
                            if (late_count_reg != CNT_MAX)
                            begin
                                late_count_next = late_count_reg + 1'b1;
                            end
                            late_sum_next = late_sum_wide[SUM_W] ? '1 : late_sum_wide[SUM_W-1:0];
                            if (late > late_peak_reg)
                            begin
                                late_peak_next = late;
                            end
                        end
                        pause_flag_next = 1'b0;

                        // Show or skip.
                        if (frame_period_reg == '0 || late < frame_period_reg ||
                            consec_skips_reg > skip_limit_reg)
                        begin
                            consec_skips_next = '0;
                            status_next       = ST_SHOWN;
                        end
                        else
                        begin
                            if (skip_count_reg != CNT_MAX)
                            begin
                                skip_count_next = skip_count_reg + 1'b1;
                            end
                            if (consec_skips_reg != '1)
                            begin
                                consec_skips_next = consec_skips_reg + 1'b1;
                            end
                            status_next = ST_SKIPPED;
                        end

                        slot_full_next[play_ptr_reg] = 1'b0;
                        play_ptr_next                = play_inc;
                        if (decoder_waiting_reg)
                        begin
                            decoder_waiting_next = 1'b0;
                            release_next         = 1'b1;
                        end

                        // Time to the following frame sets the period estimate.
                        if (slot_full_reg[play_inc])
                        begin
                            if (next_time_reg < ireg_time_reg)
                            begin
                                wait_next = '0;
                            end
                            else
                            begin
                                frame_period_next = next_time_reg - ireg_time_reg;
                                wait_next         = next_time_reg - ireg_time_reg;
                            end
                        end
                        else
                        begin
                            frame_period_next = '0;
                            wait_next         = TIME_W'(retry_wait_reg);
                        end
                    end
                end
                REQ_FLUSH_SYNC:
                begin
                    fill_blocked_next = 1'b1;
                    eof_latched_next  = 1'b0;
                    pause_flag_next   = 1'b1;
                    if (decoder_waiting_reg)
                    begin
                        decoder_waiting_next = 1'b0;
                        release_next         = 1'b1;
                    end
                    status_next = ST_FLUSHED;
                end
                REQ_FLUSH_DECODE:
                begin
                    slot_full_next    = '0;
                    play_ptr_next     = '0;
                    fill_ptr_next     = '0;
                    fill_blocked_next = 1'b0;
                    status_next       = ST_FLUSHED;
                end
                REQ_EOS:
                begin
                    eof_latched_next = 1'b1;
                    status_next      = ST_EOF;
                end
                default:
                begin
                    status_next = ST_FILL_BLOCKED;
                end
            endcase
        end
    end

    // Pacer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_full_reg       <= '0;
            play_ptr_reg        <= '0;
            fill_ptr_reg        <= '0;
            fill_blocked_reg    <= 1'b0;
            pause_flag_reg      <= 1'b1;
            eof_latched_reg     <= 1'b0;
            decoder_waiting_reg <= 1'b0;
            frame_period_reg    <= '0;
            last_fill_reg       <= '0;
            consec_skips_reg    <= '0;
            late_count_reg      <= '0;
            late_sum_reg        <= '0;
            late_peak_reg       <= '0;
            skip_count_reg      <= '0;
        end
        else
        begin
            slot_full_reg       <= slot_full_next;
            play_ptr_reg        <= play_ptr_next;
            fill_ptr_reg        <= fill_ptr_next;
            fill_blocked_reg    <= fill_blocked_next;
            pause_flag_reg      <= pause_flag_next;
            eof_latched_reg     <= eof_latched_next;
            decoder_waiting_reg <= decoder_waiting_next;
            frame_period_reg    <= frame_period_next;
            last_fill_reg       <= last_fill_next;
            consec_skips_reg    <= consec_skips_next;
            late_count_reg      <= late_count_next;
            late_sum_reg        <= late_sum_next;
            late_peak_reg       <= late_peak_next;
            skip_count_reg      <= skip_count_next;
        end
    end

    // Slot time memory: one write port, two read ports that follow the play
    // pointer, with the write of the same cycle forwarded.
    assign rd_next_addr = ptr_inc(play_ptr_next);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            display_times_mem[fill_ptr_reg] <= ireg_time_reg;
        end
        if (mem_we && fill_ptr_reg == play_ptr_next)
        begin
            head_time_reg <= ireg_time_reg;
        end
        else
        begin
            head_time_reg <= display_times_mem[play_ptr_next];
        end
        if (mem_we && fill_ptr_reg == rd_next_addr)
        begin
            next_time_reg <= ireg_time_reg;
        end
        else
        begin
            next_time_reg <= display_times_mem[rd_next_addr];
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            status_reg  <= status_next;
            wait_reg    <= wait_next;
            slot_reg    <= slot_next;
            release_reg <= release_next;
        end
    end

    // Readiness looks at the slot two thirds of the ring ahead of the play pointer.
    assign ahead_sum = {1'b0, play_ptr_reg} + AHEAD;
    assign ahead_idx = (ahead_sum >= SLOTS_W) ? PW'(ahead_sum - SLOTS_W) : ahead_sum[PW-1:0];

    // State-derived result fields only change when the next request is processed,
    // which cannot happen while a result waits, so they come straight from state.
    assign res.valid           = res_valid_reg;
    assign res.status          = status_reg;
    assign res.wait_ms         = wait_reg;
    assign res.slot            = slot_reg;
    assign res.release_decoder = release_reg;
    assign res.paused          = pause_flag_reg;
    assign res.ready_res       = !fill_blocked_reg && slot_full_reg[ahead_idx];
    assign res.head_time       = head_time_reg;
    assign res.late_frames     = late_count_reg;
    assign res.skipped_frames  = skip_count_reg;
    assign res.max_lateness    = late_peak_reg;
    assign res.total_lateness  = late_sum_reg;

`ifndef SYNTH
    // A successful fill only ever lands in an empty slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && status_next == ST_FILLED |-> !slot_full_reg[fill_ptr_reg])
        else $error("fill wrote into a full slot");

    // Presenting a frame always moves the play pointer on.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && (status_next == ST_SHOWN || status_next == ST_SKIPPED)
        |=> play_ptr_reg != $past(play_ptr_reg))
        else $error("play pointer did not advance after presenting a frame");

    // A decode flush leaves an empty ring with both pointers at the start.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && ireg_req_reg == REQ_FLUSH_DECODE
        |=> slot_full_reg == '0 && play_ptr_reg == '0 && fill_ptr_reg == '0)
        else $error("decode flush did not clear the ring");

    // The decoder is released only when it was waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && release_next |-> decoder_waiting_reg)
        else $error("decoder released while not waiting");
`endif

endmodule
